>>> rtl/tked_pkg.sv
// Shared constants, types and lookup tables for the terminal key escape decoder.
`default_nettype none

package tked_pkg;

  localparam int MAX_PENDING = 14;
  localparam int PEND_AW     = $clog2(MAX_PENDING);
  localparam int CNT_W       = $clog2(MAX_PENDING + 1);
  localparam int SUM_W       = CNT_W + 1;

  localparam int BYTE_W     = 8;
  localparam int CODE_W     = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  localparam logic [7:0] KEY_ESC  = 8'h1B;
  localparam logic [7:0] KEY_CSI  = 8'h9B;
  localparam logic [7:0] KEY_SS3  = 8'h8F;
  localparam logic [7:0] CH_LBR   = 8'h5B;
  localparam logic [7:0] CH_O     = 8'h4F;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_ETX   = 8'h03;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;

  localparam logic [8:0] CODE_ESC   = 9'd27;
  localparam logic [8:0] CODE_UP    = 9'd274;
  localparam logic [8:0] CODE_DOWN  = 9'd275;
  localparam logic [8:0] CODE_LEFT  = 9'd276;
  localparam logic [8:0] CODE_RIGHT = 9'd277;

  typedef logic [1:0] tked_mode_t;

  localparam tked_mode_t MODE_IDLE = 2'd0;
  localparam tked_mode_t MODE_ESC  = 2'd1;
  localparam tked_mode_t MODE_CSI  = 2'd2;
  localparam tked_mode_t MODE_SS3  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_NORTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOUTH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WEST  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EAST  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INTR  = 3'd4;

  typedef logic [3:0] tked_op_t;

  localparam tked_op_t OP_NONE       = 4'd0;
  localparam tked_op_t OP_START      = 4'd1;
  localparam tked_op_t OP_STORE      = 4'd2;
  localparam tked_op_t OP_TICK       = 4'd3;
  localparam tked_op_t OP_PLAIN      = 4'd4;
  localparam tked_op_t OP_HEAD_CSI   = 4'd5;
  localparam tked_op_t OP_HEAD_SS3K  = 4'd6;
  localparam tked_op_t OP_HEAD_SS3   = 4'd7;
  localparam tked_op_t OP_KEY        = 4'd8;
  localparam tked_op_t OP_TSTART     = 4'd9;
  localparam tked_op_t OP_TSTEP      = 4'd10;
  localparam tked_op_t OP_FKEY       = 4'd11;
  localparam tked_op_t OP_ESC        = 4'd12;
  localparam tked_op_t OP_PUSH_PLAIN = 4'd13;
  localparam tked_op_t OP_PUSH_LEAD  = 4'd14;
  localparam tked_op_t OP_PUSH_END   = 4'd15;

  typedef struct packed {
    tked_op_t op;
    logic     rd_scan;
  } tked_cmd_t;

  typedef struct packed {
    tked_mode_t mode;
    tked_mode_t code;
    logic       in_tick;
    logic       in_lead;
    logic       full_next;
    logic       rem_gt0;
    logic       rem_gt1;
    logic       cur_end;
    logic       b_lbr;
    logic       b_o;
    logic       b_apf;
    logic       b_tilde;
    logic       b_lead;
    logic       scan_end;
    logic       first_ok;
    logic       out_free;
  } tked_status_t;

  function automatic tked_mode_t lead_code(input logic [7:0] b);
    tked_mode_t m;
    unique case (b)
      KEY_ESC: m = MODE_ESC;
      KEY_CSI: m = MODE_CSI;
      KEY_SS3: m = MODE_SS3;
      default: m = MODE_IDLE;
    endcase
    return m;
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CH_0) && (b <= CH_9);
  endfunction

  // arrow / PF letters: A-D, P-S
  function automatic logic is_apf(input logic [7:0] b);
    return ((b >= 8'h41) && (b <= 8'h44)) || ((b >= 8'h50) && (b <= 8'h53));
  endfunction

  function automatic logic [8:0] keypad_code(input logic [7:0] b);
    logic [8:0] c;
    unique case (b)
      8'h50: c = 9'd256;  // P
      8'h51: c = 9'd257;  // Q
      8'h52: c = 9'd258;  // R
      8'h53: c = 9'd259;  // S
      8'h70: c = 9'd260;  // p
      8'h71: c = 9'd261;  // q
      8'h72: c = 9'd262;  // r
      8'h73: c = 9'd263;  // s
      8'h74: c = 9'd264;  // t
      8'h75: c = 9'd265;  // u
      8'h76: c = 9'd266;  // v
      8'h77: c = 9'd267;  // w
      8'h78: c = 9'd268;  // x
      8'h79: c = 9'd269;  // y
      8'h4D: c = 9'd270;  // M
      8'h6D: c = 9'd271;  // m
      8'h6C: c = 9'd272;  // l
      8'h6E: c = 9'd273;  // n
      8'h41: c = CODE_UP;
      8'h42: c = CODE_DOWN;
      8'h44: c = CODE_LEFT;
      8'h43: c = CODE_RIGHT;
      default: c = CODE_ESC;
    endcase
    return c;
  endfunction

  function automatic logic [8:0] fkey_code(input logic [5:0] nn);
    logic [8:0] c;
    unique case (nn)
      6'd1:  c = 9'd311;
      6'd2:  c = 9'd312;
      6'd3:  c = 9'd313;
      6'd4:  c = 9'd314;
      6'd5:  c = 9'd315;
      6'd6:  c = 9'd316;
      6'd11: c = 9'd281;
      6'd12: c = 9'd282;
      6'd13: c = 9'd283;
      6'd14: c = 9'd284;
      6'd15: c = 9'd285;
      6'd17: c = 9'd286;
      6'd18: c = 9'd287;
      6'd19: c = 9'd288;
      6'd20: c = 9'd289;
      6'd21: c = 9'd290;
      6'd23: c = 9'd291;
      6'd24: c = 9'd292;
      6'd25: c = 9'd293;
      6'd26: c = 9'd294;
      6'd28: c = 9'd295;
      6'd29: c = 9'd296;
      6'd31: c = 9'd297;
      6'd32: c = 9'd298;
      6'd33: c = 9'd299;
      6'd34: c = 9'd300;
      default: c = CODE_ESC;
    endcase
    return c;
  endfunction

  // circular buffer slot for head + offset
  function automatic logic [PEND_AW-1:0] phys_idx(input logic [SUM_W-1:0] s);
    logic [SUM_W-1:0] w;
    w = (s >= SUM_W'(MAX_PENDING)) ? s - SUM_W'(MAX_PENDING) : s;
    return w[PEND_AW-1:0];
  endfunction

endpackage

`default_nettype wire

>>> rtl/tked_if.sv
// Valid/ready channel interfaces for key input beats and decoded result beats.
`default_nettype none

interface tked_in_if import tked_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              cmd;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output cmd, output rx_byte, input ready);
  modport sink   (input valid, input cmd, input rx_byte, output ready);
endinterface

interface tked_out_if import tked_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] key_char;
  logic [CODE_W-1:0] ext_code;
  logic              interrupt_flag;
  logic              last_of_run;

  modport source (output valid, output key_char, output ext_code, output interrupt_flag,
                  output last_of_run, input ready);
  modport sink   (input valid, input key_char, input ext_code, input interrupt_flag,
                  input last_of_run, output ready);
endinterface

`default_nettype wire

>>> rtl/tked_ctrl.sv
// Sequencing state machine: accept, header check, key lookup, tilde scan, replay.
`default_nettype none

module tked_ctrl import tked_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire tked_status_t st,
  output tked_cmd_t         cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_HEAD = 3'd1;
  localparam logic [2:0] S_KEY  = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_RPL  = 3'd4;

  logic [2:0] state_r, state_nxt;
  tked_op_t   op_c;

  assign cmd = '{op: op_c, rd_scan: (state_r == S_SCAN)};

  always_comb begin
    op_c      = OP_NONE;
    state_nxt = state_r;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (st.mode == MODE_IDLE) begin
            if (!st.in_tick) begin
              if (st.in_lead) begin
                op_c = OP_START;
              end else begin
                op_c      = OP_PLAIN;
                state_nxt = S_RPL;
              end
            end
          end else if (st.in_tick) begin
            op_c      = OP_TICK;
            state_nxt = S_HEAD;
          end else begin
            op_c = OP_STORE;
            if (st.full_next) state_nxt = S_HEAD;
          end
        end
      end
      S_HEAD: begin
        state_nxt = S_KEY;
        if (st.code == MODE_ESC && st.rem_gt0) begin
          if (st.b_lbr)      op_c = OP_HEAD_CSI;
          else if (st.b_o)   op_c = OP_HEAD_SS3K;
          else if (st.b_apf) op_c = OP_HEAD_SS3;
        end
      end
      S_KEY: begin
        if (st.rem_gt0 && (st.code == MODE_SS3 || (st.code == MODE_CSI && st.b_apf))) begin
          op_c      = OP_KEY;
          state_nxt = S_RPL;
        end else if (st.rem_gt1 && st.code == MODE_CSI) begin
          op_c      = OP_TSTART;
          state_nxt = S_SCAN;
        end else begin
          op_c      = OP_ESC;
          state_nxt = S_RPL;
        end
      end
      S_SCAN: begin
        if (st.scan_end) begin
          op_c      = OP_ESC;
          state_nxt = S_RPL;
        end else if (st.b_tilde) begin
          op_c      = st.first_ok ? OP_FKEY : OP_ESC;
          state_nxt = S_RPL;
        end else begin
          op_c = OP_TSTEP;
        end
      end
      S_RPL: begin
        if (st.out_free) begin
          if (st.cur_end) begin
            op_c      = OP_PUSH_END;
            state_nxt = S_IDLE;
          end else if (st.b_lead) begin
            op_c      = OP_PUSH_LEAD;
            state_nxt = S_IDLE;
          end else begin
            op_c = OP_PUSH_PLAIN;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/tked_datapath.sv
// Pending byte buffer, parse registers, result staging and output register.
`default_nettype none

module tked_datapath import tked_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire tked_cmd_t             cmd,
  output tked_status_t               st,
  input  wire logic                  in_cmd,
  input  wire logic [BYTE_W-1:0]     in_rx_byte,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [BYTE_W-1:0]          out_key_char,
  output logic [CODE_W-1:0]          out_ext_code,
  output logic                       out_interrupt_flag,
  output logic                       out_last_of_run
);

  logic [BYTE_W-1:0] north_r, south_r, west_r, east_r;
  logic              int_en_r;

  tked_mode_t        mode_r, mode_nxt;
  tked_mode_t        c_r, c_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [PEND_AW-1:0] head_r, head_nxt;
  logic [CNT_W-1:0]  k_r, k_nxt;
  logic [CNT_W-1:0]  t_r, t_nxt;
  logic [5:0]        nn_r, nn_nxt;
  logic              run_r, run_nxt;
  logic              first_r, first_nxt;

  logic [BYTE_W-1:0] stg_key_r, stg_key_nxt;
  logic [CODE_W-1:0] stg_ext_r, stg_ext_nxt;
  logic              stg_intr_r, stg_intr_nxt;

  logic              out_valid_r;
  logic [BYTE_W-1:0] out_key_r;
  logic [CODE_W-1:0] out_ext_r;
  logic              out_intr_r;
  logic              out_last_r;
  logic              push, push_last;

  logic [BYTE_W-1:0] buf_r [MAX_PENDING];
  logic              buf_we;
  logic [PEND_AW-1:0] wr_idx, rd_idx;
  logic [CNT_W-1:0]  rd_pos;
  logic [BYTE_W-1:0] rd_byte;

  logic [9:0]        nn_sum;
  logic [5:0]        nn_sat;
  logic [CNT_W:0]    k_p1;

  logic [BYTE_W-1:0] plain_src, plain_key;
  logic              plain_intr;
  logic [CODE_W-1:0] code_new;
  logic [BYTE_W-1:0] code_key;

  assign rd_pos  = cmd.rd_scan ? t_r : k_r;
  assign rd_idx  = phys_idx(SUM_W'(head_r) + SUM_W'(rd_pos));
  assign wr_idx  = phys_idx(SUM_W'(head_r) + SUM_W'(count_r));
  assign rd_byte = buf_r[rd_idx];

  assign nn_sum = 10'(nn_r) * 10'd10 + 10'(rd_byte[3:0]);
  assign nn_sat = (nn_sum > 10'd63) ? 6'd63 : nn_sum[5:0];
  assign k_p1   = (CNT_W + 1)'(k_r) + (CNT_W + 1)'(1);

  assign st.mode      = mode_r;
  assign st.code      = c_r;
  assign st.in_tick   = in_cmd;
  assign st.in_lead   = (lead_code(in_rx_byte) != MODE_IDLE);
  assign st.full_next = (count_r == CNT_W'(MAX_PENDING - 1));
  assign st.rem_gt0   = (k_r < count_r);
  assign st.rem_gt1   = ((CNT_W + 1)'(count_r) > k_p1);
  assign st.cur_end   = (k_r == count_r);
  assign st.b_lbr     = (rd_byte == CH_LBR);
  assign st.b_o       = (rd_byte == CH_O);
  assign st.b_apf     = is_apf(rd_byte);
  assign st.b_tilde   = (rd_byte == CH_TILDE);
  assign st.b_lead    = (lead_code(rd_byte) != MODE_IDLE);
  assign st.scan_end  = (t_r == count_r);
  assign st.first_ok  = (t_r == k_r) ? is_digit(rd_byte) : first_r;
  assign st.out_free  = !out_valid_r || out_ready;

  // plain byte translation
  assign plain_src  = (cmd.op == OP_PLAIN) ? in_rx_byte : rd_byte;
  assign plain_key  = (plain_src == CH_CR) ? CH_LF : plain_src;
  assign plain_intr = (plain_src == CH_ETX) && int_en_r;

  always_comb begin
    case (cmd.op)
      OP_KEY:  code_new = keypad_code(rd_byte);
      OP_FKEY: code_new = fkey_code(nn_r);
      default: code_new = CODE_ESC;
    endcase
  end

  always_comb begin
    case (code_new)
      CODE_UP:    code_key = north_r;
      CODE_DOWN:  code_key = south_r;
      CODE_LEFT:  code_key = west_r;
      CODE_RIGHT: code_key = east_r;
      default:    code_key = KEY_ESC;
    endcase
  end

  always_comb begin
    mode_nxt     = mode_r;
    c_nxt        = c_r;
    count_nxt    = count_r;
    head_nxt     = head_r;
    k_nxt        = k_r;
    t_nxt        = t_r;
    nn_nxt       = nn_r;
    run_nxt      = run_r;
    first_nxt    = first_r;
    stg_key_nxt  = stg_key_r;
    stg_ext_nxt  = stg_ext_r;
    stg_intr_nxt = stg_intr_r;
    push         = 1'b0;
    push_last    = 1'b0;
    buf_we       = 1'b0;
    unique case (cmd.op)
      OP_NONE: ;
      OP_START: begin
        mode_nxt  = lead_code(in_rx_byte);
        count_nxt = '0;
        head_nxt  = '0;
      end
      OP_STORE: begin
        buf_we    = 1'b1;
        count_nxt = count_r + CNT_W'(1);
        c_nxt     = mode_r;
        k_nxt     = '0;
      end
      OP_TICK: begin
        c_nxt = mode_r;
        k_nxt = '0;
      end
      OP_PLAIN: begin
        stg_key_nxt  = plain_key;
        stg_ext_nxt  = CODE_W'(plain_src);
        stg_intr_nxt = plain_intr;
        k_nxt        = '0;
      end
      OP_HEAD_CSI: begin
        c_nxt = MODE_CSI;
        k_nxt = CNT_W'(1);
      end
      OP_HEAD_SS3K: begin
        c_nxt = MODE_SS3;
        k_nxt = CNT_W'(1);
      end
      OP_HEAD_SS3: c_nxt = MODE_SS3;
      OP_KEY, OP_FKEY, OP_ESC: begin
        stg_key_nxt  = code_key;
        stg_ext_nxt  = code_new;
        stg_intr_nxt = 1'b0;
        if (cmd.op == OP_KEY)  k_nxt = k_r + CNT_W'(1);
        if (cmd.op == OP_FKEY) k_nxt = t_r + CNT_W'(1);
      end
      OP_TSTART: begin
        t_nxt   = k_r;
        nn_nxt  = '0;
        run_nxt = 1'b1;
      end
      OP_TSTEP: begin
        if (run_r && is_digit(rd_byte)) nn_nxt = nn_sat;
        else run_nxt = 1'b0;
        if (t_r == k_r) first_nxt = is_digit(rd_byte);
        t_nxt = t_r + CNT_W'(1);
      end
      OP_PUSH_PLAIN: begin
        push         = 1'b1;
        stg_key_nxt  = plain_key;
        stg_ext_nxt  = CODE_W'(plain_src);
        stg_intr_nxt = plain_intr;
        k_nxt        = k_r + CNT_W'(1);
      end
      OP_PUSH_LEAD: begin
        push      = 1'b1;
        push_last = 1'b1;
        mode_nxt  = lead_code(rd_byte);
        head_nxt  = phys_idx(SUM_W'(head_r) + SUM_W'(k_r) + SUM_W'(1));
        count_nxt = count_r - k_r - CNT_W'(1);
      end
      OP_PUSH_END: begin
        push      = 1'b1;
        push_last = 1'b1;
        mode_nxt  = MODE_IDLE;
        count_nxt = '0;
        head_nxt  = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      north_r  <= 8'd107;
      south_r  <= 8'd106;
      west_r   <= 8'd104;
      east_r   <= 8'd108;
      int_en_r <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_NORTH: north_r  <= cfg_wdata;
        CFG_SOUTH: south_r  <= cfg_wdata;
        CFG_WEST:  west_r   <= cfg_wdata;
        CFG_EAST:  east_r   <= cfg_wdata;
        CFG_INTR:  int_en_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_IDLE;
      c_r         <= MODE_IDLE;
      count_r     <= '0;
      head_r      <= '0;
      k_r         <= '0;
      t_r         <= '0;
      nn_r        <= '0;
      run_r       <= 1'b0;
      first_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      mode_r  <= mode_nxt;
      c_r     <= c_nxt;
      count_r <= count_nxt;
      head_r  <= head_nxt;
      k_r     <= k_nxt;
      t_r     <= t_nxt;
      nn_r    <= nn_nxt;
      run_r   <= run_nxt;
      first_r <= first_nxt;
      if (push) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    stg_key_r  <= stg_key_nxt;
    stg_ext_r  <= stg_ext_nxt;
    stg_intr_r <= stg_intr_nxt;
    if (buf_we) buf_r[wr_idx] <= in_rx_byte;
    if (push) begin
      out_key_r  <= stg_key_r;
      out_ext_r  <= stg_ext_r;
      out_intr_r <= stg_intr_r;
      out_last_r <= push_last;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_key_char       = out_key_r;
  assign out_ext_code       = out_ext_r;
  assign out_interrupt_flag = out_intr_r;
  assign out_last_of_run    = out_last_r;

endmodule

`default_nettype wire

>>> rtl/terminal_key_escape_decoder_unit.sv
// Top level of the terminal key escape decoder: controller plus datapath.
//
// in_ch carries one beat per keyboard byte (cmd 0) or quiet-line tick (cmd 1).
// out_ch carries the decoded keys; last_of_run marks the final beat caused by
// one input beat. Some input beats (lead bytes, bytes inside a sequence, idle
// ticks) cause no result beat at all.
// cfg_we/cfg_idx/cfg_wdata write the four move keys and the interrupt enable.
// Flow: a plain byte is staged when it is accepted and moves to the output
// register from the replay state; the next input beat is taken once the
// controller is back in idle. A parse runs a header check and a key lookup,
// scans a CSI number byte by byte for its tilde, then pushes its result beats
// one at a time, each push waiting while the receiver holds the output full.
// in_ch.ready is high only while the controller waits for input; items are
// handled one at a time.
// out_ch has a single output register; while the receiver stalls the
// sequencer holds with the next result staged, and a new input beat can be
// taken while the last result of a run still waits.
// Reset (rst_n low, synchronous) returns to idle with no pending bytes and
// the default move keys and interrupt enable.
`default_nettype none

module terminal_key_escape_decoder_unit import tked_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  tked_in_if.sink                    in_ch,
  tked_out_if.source                 out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  tked_cmd_t    cmd;
  tked_status_t st;
  logic         ready_c;

  assign in_ch.ready = ready_c;

  tked_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (ready_c),
    .st       (st),
    .cmd      (cmd)
  );

  tked_datapath u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .st                 (st),
    .in_cmd             (in_ch.cmd),
    .in_rx_byte         (in_ch.rx_byte),
    .cfg_we             (cfg_we),
    .cfg_idx            (cfg_idx),
    .cfg_wdata          (cfg_wdata),
    .out_valid          (out_ch.valid),
    .out_ready          (out_ch.ready),
    .out_key_char       (out_ch.key_char),
    .out_ext_code       (out_ch.ext_code),
    .out_interrupt_flag (out_ch.interrupt_flag),
    .out_last_of_run    (out_ch.last_of_run)
  );

endmodule

`default_nettype wire

>>> rtl/tked_checker.sv
// Port-level assertions for the terminal key escape decoder, bound to the top.
`default_nettype none

module tked_checker import tked_pkg::*; (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [BYTE_W-1:0] key_char,
  input wire logic [CODE_W-1:0] ext_code,
  input wire logic              interrupt_flag,
  input wire logic              last_of_run
);

  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(key_char) && $stable(ext_code) &&
                                $stable(interrupt_flag) && $stable(last_of_run))
    else $error("result payload changed while stalled");

  a_intr_etx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && interrupt_flag |-> (ext_code == 9'd3) && (key_char == CH_ETX))
    else $error("interrupt flag on a beat that is not Ctrl-C");

  a_plain_key: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !ext_code[8] && (ext_code != 9'd13) |-> key_char == ext_code[7:0])
    else $error("plain beat key does not match its code");

  a_fkey_esc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ext_code[8] && (ext_code != CODE_UP) && (ext_code != CODE_DOWN) &&
    (ext_code != CODE_LEFT) && (ext_code != CODE_RIGHT) |-> key_char == KEY_ESC)
    else $error("non-arrow function key must emit ESC");

endmodule

bind terminal_key_escape_decoder_unit tked_checker u_tked_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .key_char       (out_ch.key_char),
  .ext_code       (out_ch.ext_code),
  .interrupt_flag (out_ch.interrupt_flag),
  .last_of_run    (out_ch.last_of_run)
);

`default_nettype wire

>>> dv/tked_key_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the key escape decoder: predicts each input beat's results, checks in order.
module tked_key_checker import tked_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  tked_in_if                    in_ch,
  tked_out_if                   out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    errors,
  output int                    keys_owed,
  output int                    beats_in,
  output int                    beats_out,
  output int                    fkey_hits,
  output int                    esc_hits
);

  localparam int OUT_LIMIT  = 16;
  localparam logic [22*8-1:0] KEYPAD = "PQRSpqrstuvwxyMmlnABDC";

  typedef struct packed {
    logic [BYTE_W-1:0] key_char;
    logic [CODE_W-1:0] ext_code;
    logic              intr;
    logic              last;
  } key_beat_t;

  logic [7:0] north_key, south_key, west_key, east_key;
  logic       intr_en;
  tked_mode_t mode;
  logic [7:0] held [MAX_PENDING];
  int         held_cnt;

  key_beat_t owed_q[$];
  key_beat_t burst_q[$];
  key_beat_t want;
  int        err_cnt, in_cnt, out_cnt, fkey_cnt, esc_cnt;

  function automatic tked_mode_t lead_kind(input logic [7:0] b);
    tked_mode_t m;
    m = MODE_IDLE;
    if (b == KEY_ESC) m = MODE_ESC;
    else if (b == KEY_CSI) m = MODE_CSI;
    else if (b == KEY_SS3) m = MODE_SS3;
    return m;
  endfunction

  function automatic bit is_num_char(input logic [7:0] b);
    return (b >= CH_0) && (b <= CH_9);
  endfunction

  function automatic bit is_cursor_letter(input logic [7:0] b);
    return ((b >= "A") && (b <= "D")) || ((b >= "P") && (b <= "S"));
  endfunction

  function automatic int keypad_pos(input logic [7:0] b);
    int pos;
    pos = -1;
    for (int i = 0; i < 22; i++) begin
      if (pos < 0 && KEYPAD[(21 - i) * 8 +: 8] == b) pos = i;
    end
    return pos;
  endfunction

  // function-key table runs in blocks of consecutive codes with gaps
  function automatic logic [8:0] fkey_of(input int nn);
    logic [8:0] c;
    c = CODE_ESC;
    if (nn >= 1 && nn <= 6) c = 9'(310 + nn);
    else if (nn >= 11 && nn <= 15) c = 9'(270 + nn);
    else if (nn >= 17 && nn <= 21) c = 9'(269 + nn);
    else if (nn >= 23 && nn <= 26) c = 9'(268 + nn);
    else if (nn >= 28 && nn <= 29) c = 9'(267 + nn);
    else if (nn >= 31 && nn <= 34) c = 9'(266 + nn);
    return c;
  endfunction

  function automatic void push_key(input logic [7:0] k, input logic [8:0] c, input logic f);
    key_beat_t kb;
    if (burst_q.size() < OUT_LIMIT) begin
      kb.key_char = k;
      kb.ext_code = c;
      kb.intr     = f;
      kb.last     = 1'b0;
      burst_q.push_back(kb);
    end
  endfunction

  function automatic void pass_byte(input logic [7:0] b);
    if (b == CH_ETX) push_key(b, {1'b0, b}, intr_en);
    else if (b == CH_CR) push_key(CH_LF, {1'b0, b}, 1'b0);
    else push_key(b, {1'b0, b}, 1'b0);
  endfunction

  function automatic void run_parse();
    tked_mode_t sel, lm;
    int         p, cnt, t, stop, nn, pos, rest;
    logic [8:0] code;
    logic [7:0] key;
    bit         done;
    sel  = mode;
    p    = 0;
    cnt  = held_cnt;
    code = CODE_ESC;
    if (sel == MODE_ESC && cnt > 0) begin
      if (held[0] == CH_LBR) begin
        sel = MODE_CSI;
        p = 1;
        cnt--;
      end else if (held[0] == CH_O) begin
        sel = MODE_SS3;
        p = 1;
        cnt--;
      end else if (is_cursor_letter(held[0])) begin
        sel = MODE_SS3;
      end
    end
    if (cnt > 0 && (sel == MODE_SS3 || (sel == MODE_CSI && is_cursor_letter(held[p])))) begin
      pos = keypad_pos(held[p]);
      if (pos >= 0) code = 9'(256 + pos);
      p++;
      cnt--;
    end else if (cnt > 1 && sel == MODE_CSI) begin
      stop = p + cnt;
      t = p;
      while (t < stop && held[t] != CH_TILDE) t++;
      if (t < stop && is_num_char(held[p])) begin
        nn = 0;
        for (int i = p; i < stop && is_num_char(held[i]); i++) begin
          nn = nn * 10 + int'(held[i]) - int'(CH_0);
          if (nn > 63) nn = 63;
        end
        if (nn > 0 && nn < 35) code = fkey_of(nn);
        cnt = cnt - (t + 1 - p);
        p = t + 1;
      end
    end
    if (code == CODE_UP) key = north_key;
    else if (code == CODE_DOWN) key = south_key;
    else if (code == CODE_LEFT) key = west_key;
    else if (code == CODE_RIGHT) key = east_key;
    else key = KEY_ESC;
    push_key(key, code, 1'b0);
    if (code >= 9'd256) fkey_cnt++;
    else esc_cnt++;

    // replay what the parse left; a lead byte restarts collection
    mode = MODE_IDLE;
    done = 1'b0;
    for (int i = p; i < p + cnt && !done; i++) begin
      lm = lead_kind(held[i]);
      if (lm != MODE_IDLE) begin
        rest = p + cnt - (i + 1);
        for (int j = 0; j < rest; j++) held[j] = held[i + 1 + j];
        held_cnt = rest;
        mode = lm;
        done = 1'b1;
      end else begin
        pass_byte(held[i]);
      end
    end
    if (!done) held_cnt = 0;
  endfunction

  function automatic void decode_beat(input logic tick, input logic [7:0] b);
    tked_mode_t lm;
    if (mode == MODE_IDLE) begin
      if (!tick) begin
        lm = lead_kind(b);
        if (lm != MODE_IDLE) begin
          mode = lm;
          held_cnt = 0;
        end else begin
          pass_byte(b);
        end
      end
    end else if (!tick) begin
      if (held_cnt < MAX_PENDING) begin
        held[held_cnt] = b;
        held_cnt++;
      end
      if (held_cnt >= MAX_PENDING) run_parse();
    end else begin
      run_parse();
    end
    if (burst_q.size() > 0) burst_q[burst_q.size() - 1].last = 1'b1;
    while (burst_q.size() > 0) owed_q.push_back(burst_q.pop_front());
  endfunction

  function automatic void cmp_field(input string what, input logic [8:0] exp_v,
                                    input logic [8:0] act_v);
    if (exp_v !== act_v) begin
      err_cnt++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, exp_v, act_v);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      north_key = 8'd107;
      south_key = 8'd106;
      west_key  = 8'd104;
      east_key  = 8'd108;
      intr_en   = 1'b1;
      mode      = MODE_IDLE;
      held_cnt  = 0;
      owed_q.delete();
      burst_q.delete();
      err_cnt   = 0;
      in_cnt    = 0;
      out_cnt   = 0;
      fkey_cnt  = 0;
      esc_cnt   = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_NORTH: north_key = cfg_wdata;
          CFG_SOUTH: south_key = cfg_wdata;
          CFG_WEST:  west_key  = cfg_wdata;
          CFG_EAST:  east_key  = cfg_wdata;
          CFG_INTR:  intr_en   = cfg_wdata[0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        out_cnt++;
        if (owed_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected result beat: expected none, actual key %0d code %0d",
                   $time, out_ch.key_char, out_ch.ext_code);
        end else begin
          want = owed_q.pop_front();
          cmp_field("key_char", {1'b0, want.key_char}, {1'b0, out_ch.key_char});
          cmp_field("ext_code", want.ext_code, out_ch.ext_code);
          cmp_field("interrupt_flag", {8'b0, want.intr}, {8'b0, out_ch.interrupt_flag});
          cmp_field("last_of_run", {8'b0, want.last}, {8'b0, out_ch.last_of_run});
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        in_cnt++;
        decode_beat(in_ch.cmd, in_ch.rx_byte);
      end
    end
    errors    <= err_cnt;
    keys_owed <= owed_q.size();
    beats_in  <= in_cnt;
    beats_out <= out_cnt;
    fkey_hits <= fkey_cnt;
    esc_hits  <= esc_cnt;
  end

endmodule

>>> dv/terminal_key_escape_decoder_unit_test.sv
`timescale 1ns / 100ps
// Testbench top for the key escape decoder: clock, reset, stimulus, back-pressure and verdict.
module terminal_key_escape_decoder_unit_test;
  import tked_pkg::*;

  localparam logic CMD_BYTE     = 1'b0;
  localparam logic CMD_TICK     = 1'b1;
  localparam int   DRAIN_CYCLES = 40;
  localparam int   HOLD_CYCLES  = 200;
  localparam int   RANDOM_ITEMS = 290;
  localparam int   PHASES       = 6;
  localparam int   HOLD_PHASE   = 2;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int errors, keys_owed, beats_in, beats_out, fkey_hits, esc_hits;
  int send_gap_max, take_gap_max, items_sent, settings_used, target;
  bit hold_req;
  logic [8:0] seq_q[$];

  tked_in_if  in_ch();
  tked_out_if out_ch();

  terminal_key_escape_decoder_unit i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  tked_key_checker i_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata),
    .errors   (errors),
    .keys_owed(keys_owed),
    .beats_in (beats_in),
    .beats_out(beats_out),
    .fkey_hits(fkey_hits),
    .esc_hits (esc_hits)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #2000000;
    $display("terminal_key_escape_decoder_unit verification failed");
    $finish;
  end

  function automatic void add_byte(input logic [7:0] b);
    seq_q.push_back({CMD_BYTE, b});
  endfunction

  function automatic void add_tick();
    seq_q.push_back({CMD_TICK, 8'($urandom_range(0, 255))});
  endfunction

  function automatic logic [7:0] any_lead();
    logic [7:0] b;
    case ($urandom_range(0, 2))
      0: b = KEY_ESC;
      1: b = KEY_CSI;
      default: b = KEY_SS3;
    endcase
    return b;
  endfunction

  function automatic void add_intro(input bit csi_only);
    int pick;
    pick = csi_only ? $urandom_range(0, 1) : $urandom_range(0, 4);
    case (pick)
      0: add_byte(KEY_CSI);
      1: begin
        add_byte(KEY_ESC);
        add_byte(CH_LBR);
      end
      2: add_byte(KEY_SS3);
      3: begin
        add_byte(KEY_ESC);
        add_byte(CH_O);
      end
      default: add_byte(KEY_ESC);
    endcase
  endfunction

  // trailing bytes replayed after the parse; sometimes a lead byte
  function automatic void add_tail();
    int n;
    n = $urandom_range(0, 2);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 7))
        0: add_byte(any_lead());
        1: add_byte(CH_CR);
        2: add_byte(CH_ETX);
        default: add_byte(8'($urandom_range(32, 126)));
      endcase
    end
  endfunction

  function automatic void build_seq();
    int         kind, nn, n;
    logic [7:0] letter;
    kind = $urandom_range(0, 99);
    if (kind < 25) begin
      case ($urandom_range(0, 5))
        0: add_byte(CH_CR);
        1: add_byte(CH_ETX);
        default: add_byte(8'($urandom_range(0, 255)));
      endcase
    end else if (kind < 55) begin
      add_intro(1'b0);
      case ($urandom_range(0, 5))
        0, 1: letter = 8'h41 + 8'($urandom_range(0, 3));
        2: letter = 8'h50 + 8'($urandom_range(0, 3));
        3: letter = 8'h6C + 8'($urandom_range(0, 13));
        4: letter = 8'h4D;
        default: letter = 8'($urandom_range(0, 255));
      endcase
      add_byte(letter);
      add_tail();
      add_tick();
    end else if (kind < 80) begin
      add_intro(1'b1);
      if ($urandom_range(0, 9) == 0) nn = $urandom_range(0, 999);
      else nn = $urandom_range(0, 40);
      if ($urandom_range(0, 9) == 0) add_byte(CH_0);
      if (nn >= 100) add_byte(CH_0 + 8'(nn / 100));
      if (nn >= 10) add_byte(CH_0 + 8'((nn / 10) % 10));
      add_byte(CH_0 + 8'(nn % 10));
      if ($urandom_range(0, 7) == 0) add_byte(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 9) != 0) add_byte(CH_TILDE);
      add_tail();
      add_tick();
    end else if (kind < 93) begin
      add_byte(any_lead());
      n = $urandom_range(0, 16);
      for (int i = 0; i < n; i++) add_byte(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 1) == 0) add_tick();
    end else begin
      add_tick();
    end
  endfunction

  task automatic send_beat(input logic c, input logic [7:0] b);
    int gap;
    gap = $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.cmd     <= c;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  task automatic send_seq();
    while (seq_q.size() > 0) begin
      send_beat(seq_q[0][8], seq_q[0][7:0]);
      void'(seq_q.pop_front());
    end
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (keys_owed != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_config(input logic [7:0] n, input logic [7:0] s, input logic [7:0] w,
                             input logic [7:0] e, input logic ie);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_NORTH;
    cfg_wdata <= n;
    @(posedge clk);
    cfg_idx   <= CFG_SOUTH;
    cfg_wdata <= s;
    @(posedge clk);
    cfg_idx   <= CFG_WEST;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_idx   <= CFG_EAST;
    cfg_wdata <= e;
    @(posedge clk);
    cfg_idx   <= CFG_INTR;
    cfg_wdata <= {7'b0, ie};
    @(posedge clk);
    cfg_we    <= 1'b0;
    settings_used++;
  endtask

  // result side: random stalls per beat, plus one long hold on request
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      stall = $urandom_range(0, take_gap_max);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  initial begin
    in_ch.valid   = 1'b0;
    in_ch.cmd     = CMD_BYTE;
    in_ch.rx_byte = 8'h00;
    cfg_we        = 1'b0;
    cfg_idx       = CFG_NORTH;
    cfg_wdata     = '0;
    rst_n         = 1'b0;
    hold_req      = 1'b0;
    send_gap_max  = 10;
    take_gap_max  = 10;
    items_sent    = 0;
    settings_used = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed beats under reset register values
    add_byte(8'h00);
    add_byte(8'hFF);
    add_byte(CH_CR);
    add_byte(CH_ETX);
    add_tick();
    add_byte(KEY_ESC);
    add_tick();
    add_byte(KEY_ESC);
    add_byte(CH_LBR);
    add_byte("A");
    add_tick();
    add_byte(KEY_CSI);
    add_byte("1");
    add_byte("5");
    add_byte(CH_TILDE);
    add_tick();
    add_byte(KEY_ESC);
    add_byte(8'h00);
    add_tick();
    add_byte(KEY_ESC);
    add_byte("x");
    add_byte(KEY_CSI);
    add_byte("2");
    add_byte(CH_TILDE);
    add_tick();
    add_tick();
    send_seq();
    wait_idle();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: load_config(8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
        1: load_config(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        default: load_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                             8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                             1'($urandom_range(0, 1)));
      endcase
      if (ph == 0) begin
        send_gap_max = 0;
        take_gap_max = 0;
      end else begin
        send_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 10;
        take_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 10;
      end
      if (ph == HOLD_PHASE) begin
        send_gap_max = 0;
        hold_req = 1'b1;
        for (int i = 0; i < 30; i++) send_beat(CMD_BYTE, 8'($urandom_range(32, 126)));
      end
      target = items_sent + RANDOM_ITEMS / PHASES;
      while (items_sent < target) begin
        build_seq();
        send_seq();
      end
      wait_idle();
    end

    $display("Run covered %0d input beats and %0d result beats over %0d register settings.",
             beats_in, beats_out, settings_used);
    $display("Function/keypad codes seen: %0d, sequences decoded as ESC: %0d.",
             fkey_hits, esc_hits);
    if (errors == 0 && keys_owed == 0) begin
      $display("terminal_key_escape_decoder_unit verification clean");
    end else begin
      $display("terminal_key_escape_decoder_unit verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/tked_pkg.sv
rtl/tked_if.sv
rtl/tked_ctrl.sv
rtl/tked_datapath.sv
rtl/terminal_key_escape_decoder_unit.sv
rtl/tked_checker.sv
dv/tked_key_checker.sv
dv/terminal_key_escape_decoder_unit_test.sv
